FILE: hw/rtl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;
	localparam int RawW = 20;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;
	localparam int QueueDepth = 4;
	localparam int DivLat = 64;
	localparam logic [63:0] FineOffset = 64'd128000;
	localparam logic [63:0] PressScale = 64'd3125;
	localparam logic [63:0] PressFull = 64'd1048576;
	localparam logic [31:0] RoundHalf = 32'd128;
	localparam logic [31:0] TempMul = 32'd5;

	typedef enum logic [CfgIdxW-1:0] {
		REG_T1 = 3'd0, REG_T23 = 3'd1, REG_P1 = 3'd2, REG_P23 = 3'd3,
		REG_P45 = 3'd4, REG_P67 = 3'd5, REG_P89 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [31:0] t23;
		logic [15:0] p1;
		logic [31:0] p23;
		logic [31:0] p45;
		logic [31:0] p67;
		logic [31:0] p89;
	} coeffs_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [31:0] tf;
		logic [31:0] tc;
		logic        zero_div;
		logic [63:0] num;
		logic [63:0] den;
	} work_t;

	typedef struct packed {
		logic [31:0] tf;
		logic [31:0] tc;
		logic [31:0] pres;
		logic        guarded;
	} result_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/ptc_in_if.sv
`default_nettype none
interface ptc_in_if;
	logic valid;
	logic ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	modport source (output valid, raw_temperature, raw_pressure, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ptc_out_if.sv
`default_nettype none
interface ptc_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] fine_temperature;
	logic signed [31:0] temperature_centideg;
	logic [31:0] pressure_q24_8;
	logic pressure_guarded;
	modport source (output valid, fine_temperature, temperature_centideg, pressure_q24_8,
		pressure_guarded, input ready);
	modport sink (input valid, fine_temperature, temperature_centideg, pressure_q24_8,
		pressure_guarded, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ptc_cfg_if.sv
`default_nettype none
interface ptc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pressure_temperature_compensation.sv
`default_nettype none
// Compensates raw temperature/pressure pairs with twelve calibration coefficients.
// One pair is accepted per cycle while the front pipeline is not stalled. A pair passes
// through the 7-stage front pipeline, the queue, the 65-register bit-per-stage divider
// and four closing stages. A stalled output holds the whole back pipeline. The user is to
// write coefficients via cfg only while the block is idle; the block does not enforce it.
module pressure_temperature_compensation import ptc_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	ptc_in_if.sink   in_ch,
	ptc_out_if.source out_ch,
	ptc_cfg_if.sink  cfg
);
	coeffs_t cf_q;
	assign cfg.ready = 1'b1;
	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cf_q <= '0;
		else if (cfg.valid) begin
			unique case (cfg.index)
				REG_T1: cf_q.t1 <= cfg.data[15:0];
				REG_T23: cf_q.t23 <= cfg.data;
				REG_P1: cf_q.p1 <= cfg.data[15:0];
				REG_P23: cf_q.p23 <= cfg.data;
				REG_P45: cf_q.p45 <= cfg.data;
				REG_P67: cf_q.p67 <= cfg.data;
				REG_P89: cf_q.p89 <= cfg.data;
				default: ;
			endcase
		end
	end
	logic fv, fr, qv, qr;
	work_t fd, qd;
	result_t rd;
	ptc_front u_front (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.raw_t(in_ch.raw_temperature), .raw_p(in_ch.raw_pressure), .cf(cf_q),
		.wv(fv), .wr(fr), .wd(fd));
	ptc_queue #(.Depth(Depth)) u_queue (.clk, .arst_n, .iv(fv), .ir(fr), .id(fd), .ov(qv),
		.or_(qr), .od(qd));
	ptc_back u_back (.clk, .arst_n, .iv(qv), .ir(qr), .id(qd), .cf(cf_q),
		.ov(out_ch.valid), .or_(out_ch.ready), .od(rd));
	assign out_ch.fine_temperature = rd.tf;
	assign out_ch.temperature_centideg = rd.tc;
	assign out_ch.pressure_q24_8 = rd.pres;
	assign out_ch.pressure_guarded = rd.guarded;

	a_guard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.pressure_guarded |-> out_ch.pressure_q24_8 == '0)
		else $error("guarded result has nonzero pressure");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped while stalled");
endmodule
`default_nettype wire

FILE: hw/rtl/ptc_front.sv
`default_nettype none
module ptc_front import ptc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [RawW-1:0] raw_t,
	input  wire logic [RawW-1:0] raw_p,
	input  wire coeffs_t cf,
	output logic      wv,
	input  wire logic wr,
	output work_t     wd
);
	// pipeline: s1 temp products, s2 shifted terms, s3 fine temp, s4..s6 pressure, s7 out
	localparam int NS = 7;
	logic [NS-1:0] v_q;
	logic adv;
	assign adv = !v_q[NS-1] || wr;
	assign in_ready = adv;
	assign wv = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], in_valid};
	end

	logic [31:0] a_s1, sq_s1; logic [RawW-1:0] rp_s1;
	logic [31:0] a_s2, b_s2; logic [RawW-1:0] rp_s2;
	logic [31:0] tf_s3, tc_s3; logic [63:0] v1_s3; logic [RawW-1:0] rp_s3;
	logic [31:0] tf_s4, tc_s4; logic [63:0] vv_s4, v1p5_s4, v1p2_s4; logic [RawW-1:0] rp_s4;
	logic [31:0] tf_s5, tc_s5; logic [63:0] v2_s5, c_s5, vv3_s5; logic [RawW-1:0] rp_s5;
	logic [31:0] tf_s6, tc_s6; logic [63:0] v2_s6, den_s6; logic [RawW-1:0] rp_s6;
	logic [31:0] d1, d2, tmul, tfw;
	logic [63:0] p1s, pr;
	always_comb begin
		d1 = {15'd0, raw_t[RawW-1:3]} - {15'd0, cf.t1, 1'b0};
		d2 = {16'd0, raw_t[RawW-1:4]} - {16'd0, cf.t1};
		tfw = a_s2 + b_s2;
		tmul = tfw * TempMul + RoundHalf;
		p1s = $signed($signed(vv3_s5) >>> 8) + c_s5 + 64'h0000_8000_0000_0000;
		pr = PressFull - {44'd0, rp_s6};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= d1 * {{16{cf.t23[15]}}, cf.t23[15:0]};
			sq_s1 <= d2 * d2; rp_s1 <= raw_p;
			a_s2 <= $signed(a_s1) >>> 11;
			b_s2 <= ($signed($signed(sq_s1) >>> 12) * $signed({{16{cf.t23[31]}}, cf.t23[31:16]}))
				>>> 14;
			rp_s2 <= rp_s1;
			tf_s3 <= tfw; tc_s3 <= $signed(tmul) >>> 8;
			v1_s3 <= {{32{tfw[31]}}, tfw} - FineOffset;
			rp_s3 <= rp_s2;
			tf_s4 <= tf_s3; tc_s4 <= tc_s3; rp_s4 <= rp_s3;
			// offset fine temperature fits in 33 signed bits
			vv_s4 <= $signed(v1_s3[32:0]) * $signed(v1_s3[32:0]);
			v1p5_s4 <= v1_s3 * sx16(cf.p45[31:16]);
			v1p2_s4 <= v1_s3 * sx16(cf.p23[15:0]);
			tf_s5 <= tf_s4; tc_s5 <= tc_s4; rp_s5 <= rp_s4;
			v2_s5 <= vv_s4 * sx16(cf.p67[15:0]) + (v1p5_s4 << 17) + (sx16(cf.p45[15:0]) << 35);
			vv3_s5 <= vv_s4 * sx16(cf.p23[31:16]);
			c_s5 <= v1p2_s4 << 12;
			tf_s6 <= tf_s5; tc_s6 <= tc_s5; rp_s6 <= rp_s5; v2_s6 <= v2_s5;
			den_s6 <= $signed(p1s * {48'd0, cf.p1}) >>> 33;
			wd.tf <= tf_s6; wd.tc <= tc_s6; wd.den <= den_s6;
			wd.zero_div <= den_s6 == '0;
			wd.num <= ((pr << 31) - v2_s6) * PressScale;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/ptc_queue.sv
`default_nettype none
module ptc_queue import ptc_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic iv,
	output logic      ir,
	input  wire work_t id,
	output logic      ov,
	input  wire logic or_,
	output work_t     od
);
	localparam int AW = $clog2(Depth);
	work_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;
	assign ir = cnt_q != Depth[AW:0];
	assign ov = cnt_q != '0;
	assign od = mem_q[rp_q];
	assign push = iv && ir;
	assign pop = ov && or_;
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= id;
	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/ptc_back.sv
`default_nettype none
module ptc_back import ptc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic iv,
	output logic      ir,
	input  wire work_t id,
	input  wire coeffs_t cf,
	output logic      ov,
	input  wire logic or_,
	output result_t   od
);
	// pipelined restoring divider, one quotient bit per stage
	logic [DivLat:0] v_q;
	logic [3:0] tail_q;
	logic adv;
	assign adv = !tail_q[3] || or_;
	assign ir = adv;
	logic [63:0] rem_q [DivLat+1];
	logic [63:0] quo_q [DivLat+1];
	logic [63:0] dv_q [DivLat+1];
	logic neg_q [DivLat+1];
	logic z_q [DivLat+1];
	logic [31:0] tf_q [DivLat+1];
	logic [31:0] tc_q [DivLat+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[DivLat-1:0], iv};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= '0;
			quo_q[0] <= id.num[63] ? -id.num : id.num;
			dv_q[0] <= id.den[63] ? -id.den : id.den;
			neg_q[0] <= id.num[63] ^ id.den[63];
			z_q[0] <= id.zero_div; tf_q[0] <= id.tf; tc_q[0] <= id.tc;
		end
	end
	for (genvar i = 0; i < DivLat; i++) begin : g_div
		logic [64:0] tr, df;
		always_comb begin
			tr = {rem_q[i], quo_q[i][63]};
			df = tr - {1'b0, dv_q[i]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1] <= df[64] ? tr[63:0] : df[63:0];
				quo_q[i+1] <= {quo_q[i][62:0], !df[64]};
				dv_q[i+1] <= dv_q[i]; neg_q[i+1] <= neg_q[i]; z_q[i+1] <= z_q[i];
				tf_q[i+1] <= tf_q[i]; tc_q[i+1] <= tc_q[i];
			end
		end
	end
	// post-division terms, four stages; the wide product is split into 32-bit partials
	logic [63:0] p_s1, q_s1, p9q_s1;
	logic [63:0] p_s2, b_s2, ll_s2;
	logic [31:0] hl_s2, lh_s2;
	logic [63:0] p_s3, b_s3, a_s3;
	logic [31:0] tf_s1, tc_s1, tf_s2, tc_s2, tf_s3, tc_s3;
	logic z_s1, z_s2, z_s3;
	logic [63:0] pq, qc, p9qq, sum3, psum, pfin;
	always_comb begin
		pq = neg_q[DivLat] ? -quo_q[DivLat] : quo_q[DivLat];
		qc = $signed(pq) >>> 13;
		p9qq = ll_s2 + {hl_s2 + lh_s2, 32'd0};
		sum3 = p_s3 + a_s3 + b_s3;
		psum = $signed(sum3) >>> 8;
		pfin = psum + (sx16(cf.p67[31:16]) << 4);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= pq; q_s1 <= qc; tf_s1 <= tf_q[DivLat];
			tc_s1 <= tc_q[DivLat]; z_s1 <= z_q[DivLat];
			p9q_s1 <= sx16(cf.p89[31:16]) * qc;
			p_s2 <= p_s1; z_s2 <= z_s1; tf_s2 <= tf_s1; tc_s2 <= tc_s1;
			ll_s2 <= {32'd0, p9q_s1[31:0]} * {32'd0, q_s1[31:0]};
			hl_s2 <= p9q_s1[63:32] * q_s1[31:0];
			lh_s2 <= p9q_s1[31:0] * q_s1[63:32];
			b_s2 <= $signed(sx16(cf.p89[15:0]) * p_s1) >>> 19;
			p_s3 <= p_s2; b_s3 <= b_s2; z_s3 <= z_s2; tf_s3 <= tf_s2; tc_s3 <= tc_s2;
			a_s3 <= $signed(p9qq) >>> 25;
			od.tf <= tf_s3; od.tc <= tc_s3; od.guarded <= z_s3;
			od.pres <= z_s3 ? '0 : pfin[31:0];
		end
	end
	// valid tracks the divider chain plus four post stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tail_q <= '0;
		else if (adv) tail_q <= {tail_q[2:0], v_q[DivLat]};
	end
	assign ov = tail_q[3];
endmodule
`default_nettype wire
